// ----- rtl/sltb_pkg.sv -----
// ----------------------------------------------------------------------------
// sltb_pkg
// Shared types and constants of the sorted leaf table: field widths, request
// and status codes, controller states and the command and status structs.
// ----------------------------------------------------------------------------
package sltb_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 9;
    localparam int MAX_W    = 9;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_INSERTED    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UPDATED     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DELETED     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_MISS_SEARCH = 3'd4;

    localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = 9'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_PROBE,
        ST_MOVE,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic                load;
        logic                srch_rd;
        logic                srch_cmp;
        logic                probe_rd;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
        logic                wr_update;
        logic                move_up;
        logic                move_down;
        logic                move_step;
        logic                wr_final;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                out_load;
    } t_cmd;

    typedef struct packed {
        logic lo_lt_hi;
        logic hit;
        logic full;
        logic op_insert;
        logic op_delete;
        logic move_done;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/sltb_ram.sv -----
// ----------------------------------------------------------------------------
// sltb_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sltb_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sltb_ctrl.sv -----
// ----------------------------------------------------------------------------
// sltb_ctrl
// Controller of the sorted leaf table: sequences the binary search, the probe
// of the lower-bound entry, the entry shift and the result transaction.
// ----------------------------------------------------------------------------
module sltb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sltb_pkg::t_stat i_stat,
    output sltb_pkg::t_cmd  o_cmd
);

    sltb_pkg::t_state r_state;
    sltb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sltb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sltb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = sltb_pkg::ST_SRCH;
                end
            end
            sltb_pkg::ST_SRCH: begin
                n_state = i_stat.lo_lt_hi ? sltb_pkg::ST_SRCH_CMP : sltb_pkg::ST_PROBE;
            end
            sltb_pkg::ST_SRCH_CMP: begin
                n_state = sltb_pkg::ST_SRCH;
            end
            sltb_pkg::ST_PROBE: begin
                if (i_stat.op_insert) begin
                    n_state = (!i_stat.full && !i_stat.hit) ? sltb_pkg::ST_MOVE
                                                            : sltb_pkg::ST_RESULT;
                end else if (i_stat.op_delete) begin
                    n_state = i_stat.hit ? sltb_pkg::ST_MOVE : sltb_pkg::ST_RESULT;
                end else begin
                    n_state = sltb_pkg::ST_RESULT;
                end
            end
            sltb_pkg::ST_MOVE: begin
                if (i_stat.move_done) begin
                    n_state = sltb_pkg::ST_RESULT;
                end
            end
            sltb_pkg::ST_RESULT: begin
                if (i_stat.out_free) begin
                    n_state = sltb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sltb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sltb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            sltb_pkg::ST_SRCH: begin
                o_cmd.srch_rd  = i_stat.lo_lt_hi;
                o_cmd.probe_rd = !i_stat.lo_lt_hi;
            end
            sltb_pkg::ST_SRCH_CMP: begin
                o_cmd.srch_cmp = 1'b1;
            end
            sltb_pkg::ST_PROBE: begin
                o_cmd.set_status = 1'b1;
                if (i_stat.op_insert) begin
                    if (i_stat.full) begin
                        o_cmd.status_code = sltb_pkg::STAT_FULL;
                    end else if (i_stat.hit) begin
                        o_cmd.status_code = sltb_pkg::STAT_UPDATED;
                        o_cmd.wr_update   = 1'b1;
                    end else begin
                        o_cmd.status_code = sltb_pkg::STAT_INSERTED;
                        o_cmd.move_up     = 1'b1;
                    end
                end else if (i_stat.op_delete && i_stat.hit) begin
                    o_cmd.status_code = sltb_pkg::STAT_DELETED;
                    o_cmd.move_down   = 1'b1;
                end else begin
                    o_cmd.status_code = sltb_pkg::STAT_MISS_SEARCH;
                end
            end
            sltb_pkg::ST_MOVE: begin
                o_cmd.move_step = 1'b1;
                if (i_stat.move_done) begin
                    o_cmd.wr_final = i_stat.op_insert;
                    o_cmd.cnt_inc  = i_stat.op_insert;
                    o_cmd.cnt_dec  = !i_stat.op_insert;
                end
            end
            sltb_pkg::ST_RESULT: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/sltb_dpath.sv -----
// ----------------------------------------------------------------------------
// sltb_dpath
// Datapath of the sorted leaf table: entry RAM, search bounds, entry count,
// shift engine and the result register.
// ----------------------------------------------------------------------------
module sltb_dpath #(
    parameter int CAPACITY = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sltb_pkg::t_cmd                        i_cmd,
    output sltb_pkg::t_stat                       o_stat,
    input  logic [sltb_pkg::MAX_W-1:0]            i_max_entries,
    input  logic [sltb_pkg::OP_W-1:0]             i_opcode,
    input  logic signed [sltb_pkg::KEY_W-1:0]     i_key,
    input  logic [sltb_pkg::VAL_W-1:0]            i_value,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic [sltb_pkg::STATUS_W-1:0]         o_status,
    output logic [sltb_pkg::POS_W-1:0]            o_position,
    output logic signed [sltb_pkg::KEY_W-1:0]     o_found_key,
    output logic [sltb_pkg::VAL_W-1:0]            o_found_value,
    output logic                                  o_entry_valid,
    output logic [sltb_pkg::POS_W-1:0]            o_count_after
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int LW = (CW > sltb_pkg::MAX_W) ? CW : sltb_pkg::MAX_W;
    localparam int DW = sltb_pkg::KEY_W + sltb_pkg::VAL_W;
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    logic [sltb_pkg::OP_W-1:0]         r_op;
    logic signed [sltb_pkg::KEY_W-1:0] r_key;
    logic [sltb_pkg::VAL_W-1:0]        r_val;
    logic [CW-1:0]                     r_lo;
    logic [CW-1:0]                     r_hi;
    logic [CW-1:0]                     r_mid;
    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     r_src;
    logic [CW-1:0]                     r_left;
    logic [AW-1:0]                     r_wdst;
    logic                              r_wpend;
    logic                              r_dir_up;

    logic [sltb_pkg::STATUS_W-1:0]     r_status;
    logic signed [sltb_pkg::KEY_W-1:0] r_fkey;
    logic [sltb_pkg::VAL_W-1:0]        r_fval;
    logic                              r_evalid;

    logic                              r_out_valid;
    logic [sltb_pkg::STATUS_W-1:0]     r_o_status;
    logic [sltb_pkg::POS_W-1:0]        r_o_pos;
    logic signed [sltb_pkg::KEY_W-1:0] r_o_fkey;
    logic [sltb_pkg::VAL_W-1:0]        r_o_fval;
    logic                              r_o_evalid;
    logic [sltb_pkg::POS_W-1:0]        r_o_count;

    logic [CW-1:0]                     w_mid;
    logic [CW-1:0]                     w_src_up;
    logic [CW-1:0]                     w_src_dn;
    logic                              w_lo_in;
    logic                              w_is_search;
    logic [LW-1:0]                     w_max_l;
    logic [LW-1:0]                     w_limit;
    logic [LW-1:0]                     w_count_l;
    logic [LW-1:0]                     w_lo_l;
    logic                              w_out_free;

    logic                              w_we;
    logic [AW-1:0]                     w_waddr;
    logic [DW-1:0]                     w_wdata;
    logic [AW-1:0]                     w_raddr;
    logic [DW-1:0]                     w_rdata;
    logic signed [sltb_pkg::KEY_W-1:0] w_rd_key;
    logic [sltb_pkg::VAL_W-1:0]        w_rd_val;

    assign w_mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign w_src_up    = r_src + 1'b1;
    assign w_src_dn    = r_src - 1'b1;
    assign w_lo_in     = (r_lo < r_count);
    assign w_is_search = (r_op != sltb_pkg::OP_INSERT) && (r_op != sltb_pkg::OP_DELETE);
    assign w_max_l     = LW'(i_max_entries);
    assign w_limit     = (w_max_l < CAP_L) ? w_max_l : CAP_L;
    assign w_count_l   = LW'(r_count);
    assign w_lo_l      = LW'(r_lo);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_rd_key    = w_rdata[DW-1:sltb_pkg::VAL_W];
    assign w_rd_val    = w_rdata[sltb_pkg::VAL_W-1:0];

    always_comb begin
        w_raddr = r_src[AW-1:0];
        if (i_cmd.srch_rd) begin
            w_raddr = w_mid[AW-1:0];
        end else if (i_cmd.probe_rd) begin
            w_raddr = w_lo_in ? r_lo[AW-1:0] : '0;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_lo[AW-1:0];
        w_wdata = {r_key, r_val};
        if (i_cmd.move_step && r_wpend) begin
            w_we    = 1'b1;
            w_waddr = r_wdst;
            w_wdata = w_rdata;
        end else if (i_cmd.wr_update || i_cmd.wr_final) begin
            w_we = 1'b1;
        end
    end

    sltb_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_key <= i_key;
            r_val <= i_value;
            r_lo  <= '0;
            r_hi  <= r_count;
        end
        if (i_cmd.srch_rd) begin
            r_mid <= w_mid;
        end
        if (i_cmd.srch_cmp) begin
            if (w_rd_key < r_key) begin
                r_lo <= r_mid + 1'b1;
            end else begin
                r_hi <= r_mid;
            end
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
            if (w_is_search && w_lo_in) begin
                r_fkey   <= w_rd_key;
                r_fval   <= w_rd_val;
                r_evalid <= 1'b1;
            end else begin
                r_fkey   <= '0;
                r_fval   <= '0;
                r_evalid <= 1'b0;
            end
        end
        if (i_cmd.move_up) begin
            r_left   <= r_count - r_lo;
            r_src    <= r_count - 1'b1;
            r_dir_up <= 1'b1;
        end else if (i_cmd.move_down) begin
            r_left   <= r_count - r_lo - 1'b1;
            r_src    <= r_lo + 1'b1;
            r_dir_up <= 1'b0;
        end else if (i_cmd.move_step && (r_left != '0)) begin
            r_left <= r_left - 1'b1;
            r_src  <= r_dir_up ? w_src_dn : w_src_up;
            r_wdst <= r_dir_up ? w_src_up[AW-1:0] : w_src_dn[AW-1:0];
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_pos    <= w_lo_l[sltb_pkg::POS_W-1:0];
            r_o_fkey   <= r_fkey;
            r_o_fval   <= r_fval;
            r_o_evalid <= r_evalid;
            r_o_count  <= w_count_l[sltb_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.move_up || i_cmd.move_down) begin
                r_wpend <= 1'b0;
            end else if (i_cmd.move_step) begin
                r_wpend <= (r_left != '0);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.lo_lt_hi  = (r_lo < r_hi);
    assign o_stat.hit       = w_lo_in && (w_rd_key == r_key);
    assign o_stat.full      = (w_count_l >= w_limit);
    assign o_stat.op_insert = (r_op == sltb_pkg::OP_INSERT);
    assign o_stat.op_delete = (r_op == sltb_pkg::OP_DELETE);
    assign o_stat.move_done = (r_left == '0) && !r_wpend;
    assign o_stat.out_free  = w_out_free;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_position    = r_o_pos;
    assign o_found_key   = r_o_fkey;
    assign o_found_value = r_o_fval;
    assign o_entry_valid = r_o_evalid;
    assign o_count_after = r_o_count;

endmodule

// ----- rtl/sorted_leaf_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_leaf_table_core
// One B+ tree leaf kept as a sorted key/value array with insert, update,
// delete and lower-bound search, plus an entry limit register.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Payload
//  request   in         i_in_valid / o_in_ready     i_opcode, i_key, i_value
//  result    out        o_out_valid / i_out_ready   o_status .. o_count_after
//  config    in         psel, penable, pwrite       paddr, pwdata, prdata
//
//  One request is handled at a time. Each binary search step passes through a
//  read state and a compare state over the entry RAM read port, followed by a
//  probe state. An insert or delete then shifts the later entries one per
//  cycle. A stalled result transaction holds the controller in its result
//  state; the next request is taken once the result has been registered.
//  Reset clears the entry count and sets the limit to 256; the RAM is not
//  cleared.
// ----------------------------------------------------------------------------
module sorted_leaf_table_core #(
    parameter int CAPACITY = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [sltb_pkg::OP_W-1:0]             i_opcode,
    input  logic signed [sltb_pkg::KEY_W-1:0]     i_key,
    input  logic [sltb_pkg::VAL_W-1:0]            i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [sltb_pkg::STATUS_W-1:0]         o_status,
    output logic [sltb_pkg::POS_W-1:0]            o_position,
    output logic signed [sltb_pkg::KEY_W-1:0]     o_found_key,
    output logic [sltb_pkg::VAL_W-1:0]            o_found_value,
    output logic                                  o_entry_valid,
    output logic [sltb_pkg::POS_W-1:0]            o_count_after,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sltb_pkg::APB_AW-1:0]           paddr,
    input  logic [sltb_pkg::APB_DW-1:0]           pwdata,
    output logic [sltb_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready
);

    logic [sltb_pkg::MAX_W-1:0] r_max_entries;
    logic                       w_cfg_wr;
    sltb_pkg::t_cmd             w_cmd;
    sltb_pkg::t_stat            w_stat;

    // The port holds a single register, so every word address selects it.
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = {{(sltb_pkg::APB_DW - sltb_pkg::MAX_W){1'b0}}, r_max_entries};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= sltb_pkg::MAX_ENTRIES_RESET;
        end else if (w_cfg_wr) begin
            r_max_entries <= pwdata[sltb_pkg::MAX_W-1:0];
        end
    end

    sltb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sltb_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_max_entries (r_max_entries),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_found_key   (o_found_key),
        .o_found_value (o_found_value),
        .o_entry_valid (o_entry_valid),
        .o_count_after (o_count_after)
    );

endmodule

// ----- rtl/sltb_checker.sv -----
// ----------------------------------------------------------------------------
// sltb_checker
// Port-level checks on the result channel of the sorted leaf table.
// ----------------------------------------------------------------------------
module sltb_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic [sltb_pkg::STATUS_W-1:0]     o_status,
    input  logic signed [sltb_pkg::KEY_W-1:0] o_found_key,
    input  logic [sltb_pkg::VAL_W-1:0]        o_found_value,
    input  logic                              o_entry_valid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Result transaction dropped before it was taken.");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == sltb_pkg::STAT_INSERTED) ||
                        (o_status == sltb_pkg::STAT_UPDATED) ||
                        (o_status == sltb_pkg::STAT_FULL) ||
                        (o_status == sltb_pkg::STAT_DELETED) ||
                        (o_status == sltb_pkg::STAT_MISS_SEARCH))
        else $error("Result status code out of range.");

    a_valid_only_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_entry_valid |-> o_status == sltb_pkg::STAT_MISS_SEARCH)
        else $error("Entry flagged valid on a non-search result.");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_entry_valid |-> (o_found_key == '0) && (o_found_value == '0))
        else $error("Found entry fields not zero without a valid entry.");

endmodule

bind sorted_leaf_table_core sltb_checker u_sltb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_found_key   (o_found_key),
    .o_found_value (o_found_value),
    .o_entry_valid (o_entry_valid)
);
